// ----- sv/ghmt_pkg.sv -----
// shared types and constants for the goal histogram max tracker
package ghmt_pkg;

    localparam int MIN_GOAL = 1;
    localparam int KIND_W   = 2;
    localparam int GOAL_W   = 8;
    localparam int STATUS_W = 2;
    localparam int EFF_W    = 5;
    localparam int TOTAL_W  = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CHANGE = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_ABSENT   = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [GOAL_W-1:0] goal;
        logic [GOAL_W-1:0] prev_goal;
    } event_t;

    typedef struct packed {
        status_t            status;
        logic [EFF_W-1:0]   effective_goal;
        logic [TOTAL_W-1:0] file_total;
    } result_t;

endpackage

// ----- sv/ghmt_if.sv -----
// valid/ready channel interfaces for events and results

interface ghmt_evt_if;
    logic                         valid;
    logic                         ready;
    logic [ghmt_pkg::KIND_W-1:0]  kind;
    logic [ghmt_pkg::GOAL_W-1:0]  goal;
    logic [ghmt_pkg::GOAL_W-1:0]  prev_goal;

    modport source (output valid, output kind, output goal, output prev_goal, input ready);
    modport sink (input valid, input kind, input goal, input prev_goal, output ready);
endinterface

interface ghmt_res_if;
    logic                          valid;
    logic                          ready;
    logic [ghmt_pkg::STATUS_W-1:0] status;
    logic [ghmt_pkg::EFF_W-1:0]    effective_goal;
    logic [ghmt_pkg::TOTAL_W-1:0]  file_total;

    modport source (output valid, output status, output effective_goal, output file_total,
                    input ready);
    modport sink (input valid, input status, input effective_goal, input file_total,
                  output ready);
endinterface

// ----- sv/ghmt_core.sv -----
// per-goal counters, event checks and highest-goal encoder
module ghmt_core #(
    parameter int MAX_GOAL    = 20,
    parameter int COUNT_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  ghmt_pkg::event_t  ev,
    output ghmt_pkg::result_t res
);

    localparam int SLOTS  = MAX_GOAL - ghmt_pkg::MIN_GOAL + 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [ghmt_pkg::GOAL_W-1:0] MIN_G = ghmt_pkg::GOAL_W'(ghmt_pkg::MIN_GOAL);
    localparam logic [ghmt_pkg::GOAL_W-1:0] MAX_G = ghmt_pkg::GOAL_W'(MAX_GOAL);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] ONE = COUNT_WIDTH'(1);

    logic [COUNT_WIDTH-1:0] count_reg [SLOTS];
    logic [COUNT_WIDTH-1:0] count_next [SLOTS];
    logic [COUNT_WIDTH-1:0] total_reg;
    logic [COUNT_WIDTH-1:0] total_next;

    logic              g_ok;
    logic              pg_ok;
    logic [SLOT_W-1:0] g_slot;
    logic [SLOT_W-1:0] pg_slot;
    logic [SLOTS-1:0]  sel_g;
    logic [SLOTS-1:0]  sel_pg;
    logic [SLOTS-1:0]  nz;
    logic [SLOTS-1:0]  full;
    logic [SLOTS-1:0]  inc;
    logic [SLOTS-1:0]  dec;
    logic              tot_inc;
    logic              tot_dec;
    logic              g_nz;
    logic              g_full;
    logic              pg_nz;
    logic              total_full;
    ghmt_pkg::status_t status;
    logic [ghmt_pkg::EFF_W-1:0] eff;

    assign g_ok    = (ev.goal >= MIN_G) && (ev.goal <= MAX_G);
    assign pg_ok   = (ev.prev_goal >= MIN_G) && (ev.prev_goal <= MAX_G);
    assign g_slot  = SLOT_W'(ev.goal - MIN_G);
    assign pg_slot = SLOT_W'(ev.prev_goal - MIN_G);

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            sel_g[i]  = g_ok && (g_slot == SLOT_W'(i));
            sel_pg[i] = pg_ok && (pg_slot == SLOT_W'(i));
            nz[i]     = count_reg[i] != '0;
            full[i]   = count_reg[i] == COUNT_MAX;
        end
    end

    assign g_nz       = |(sel_g & nz);
    assign g_full     = |(sel_g & full);
    assign pg_nz      = |(sel_pg & nz);
    assign total_full = total_reg == COUNT_MAX;

    always_comb
    begin
        status  = ghmt_pkg::ST_OK;
        inc     = '0;
        dec     = '0;
        tot_inc = 1'b0;
        tot_dec = 1'b0;
        case (ghmt_pkg::kind_t'(ev.kind))
            ghmt_pkg::KIND_ADD:
            begin
                if (!g_ok)
                    status = ghmt_pkg::ST_INVALID;
                else if (g_full || total_full)
                    status = ghmt_pkg::ST_OVERFLOW;
                else
                begin
                    inc     = sel_g;
                    tot_inc = 1'b1;
                end
            end
            ghmt_pkg::KIND_REMOVE:
            begin
                if (!g_ok)
                    status = ghmt_pkg::ST_INVALID;
                else if (!g_nz)
                    status = ghmt_pkg::ST_ABSENT;
                else
                begin
                    dec     = sel_g;
                    tot_dec = 1'b1;
                end
            end
            ghmt_pkg::KIND_CHANGE:
            begin
                if (!g_ok || !pg_ok)
                    status = ghmt_pkg::ST_INVALID;
                else if (!pg_nz)
                    status = ghmt_pkg::ST_ABSENT;
                else if (ev.goal != ev.prev_goal)
                begin
                    inc = sel_g;
                    dec = sel_pg;
                end
            end
            default:
            begin
                status = ghmt_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            if (inc[i])
                count_next[i] = count_reg[i] + ONE;
            else if (dec[i])
                count_next[i] = count_reg[i] - ONE;
            else
                count_next[i] = count_reg[i];
        end
        if (tot_inc)
            total_next = total_reg + ONE;
        else if (tot_dec)
            total_next = total_reg - ONE;
        else
            total_next = total_reg;
    end

    // highest slot with a nonzero count after the update
    always_comb
    begin
        eff = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (count_next[i] != '0)
                eff = ghmt_pkg::EFF_W'(i + ghmt_pkg::MIN_GOAL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                count_reg[i] <= '0;
            total_reg <= '0;
        end
        else if (fire)
        begin
            for (int i = 0; i < SLOTS; i++)
                count_reg[i] <= count_next[i];
            total_reg <= total_next;
        end
    end

    assign res.status         = status;
    assign res.effective_goal = eff;
    assign res.file_total     = ghmt_pkg::TOTAL_W'(total_next);

endmodule

// ----- sv/goal_histogram_max_tracker_unit.sv -----
// top level of the goal histogram max tracker
// Counts files per replication goal (goals 1 to MAX_GOAL) and in total, taking add, remove
// and change-goal transactions on evt and returning one result per transaction on res: a
// status, the highest goal that still has files (0 when empty, low five bits) and the file
// total after the transaction. Rejected transactions (invalid goal, absent goal, overflow)
// change nothing. A transaction is registered in ev_reg on acceptance and its result is registered
// in res_reg when the core fires; one transaction is taken every cycle unless res holds back,
// and the counters update with the result register; only back pressure on res slows acceptance.
// Counters clear on reset; there is no clearing pass.
module goal_histogram_max_tracker_unit #(
    parameter int MAX_GOAL    = 20,
    parameter int COUNT_WIDTH = 32
) (
    input logic       clk,
    input logic       rst_n,
    ghmt_evt_if.sink  evt,
    ghmt_res_if.source res
);

    ghmt_pkg::event_t  ev_reg;
    logic              ev_valid_reg;
    ghmt_pkg::result_t res_reg;
    logic              res_valid_reg;
    ghmt_pkg::result_t core_res;
    logic              advance;
    logic              fire;

    assign advance   = !res_valid_reg || res.ready;
    assign fire      = ev_valid_reg && advance;
    assign evt.ready = !ev_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ev_valid_reg <= 1'b0;
        else if (evt.ready)
            ev_valid_reg <= evt.valid;
    end

    always_ff @(posedge clk)
    begin
        if (evt.ready && evt.valid)
        begin
            ev_reg.kind      <= evt.kind;
            ev_reg.goal      <= evt.goal;
            ev_reg.prev_goal <= evt.prev_goal;
        end
    end

    ghmt_core #(
        .MAX_GOAL    (MAX_GOAL),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .ev    (ev_reg),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= ev_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= core_res;
    end

    assign res.valid          = res_valid_reg;
    assign res.status         = res_reg.status;
    assign res.effective_goal = res_reg.effective_goal;
    assign res.file_total     = res_reg.file_total;

endmodule

// ----- sim/goal_histogram_max_tracker_unit_tb.sv -----
// testbench for the goal histogram max tracker: directed, fill and drain, back pressure and random runs
`timescale 1ns / 1ps

module goal_histogram_max_tracker_unit_tb;

    localparam int MAX_GOAL    = 20;
    localparam int COUNT_WIDTH = 32;
    localparam int LIMIT       = 400000;
    localparam logic [ghmt_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = '1;

    logic clk;
    logic rst_n;

    ghmt_evt_if evt_bus ();
    ghmt_res_if res_bus ();

    goal_histogram_max_tracker_unit #(
        .MAX_GOAL   (MAX_GOAL),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .evt  (evt_bus),
        .res  (res_bus)
    );

    logic [COUNT_WIDTH-1:0] goal_count [ghmt_pkg::MIN_GOAL:MAX_GOAL];
    logic [COUNT_WIDTH-1:0] file_count;
    ghmt_pkg::result_t      results_due[$];
    int                     mismatches;
    int                     cycle_count;
    int                     burst_left;
    bit                     gaps_on;
    int                     hold_req;
    int                     hold_len;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic bit goal_valid(input logic [ghmt_pkg::GOAL_W-1:0] g);
        return g >= ghmt_pkg::MIN_GOAL && g <= MAX_GOAL;
    endfunction

    function automatic logic [ghmt_pkg::EFF_W-1:0] top_goal();
        for (int g = MAX_GOAL; g >= ghmt_pkg::MIN_GOAL; g--)
        begin
            if (goal_count[g] != '0)
                return ghmt_pkg::EFF_W'(g);
        end
        return '0;
    endfunction

    // updates the histogram and returns the result the block should report
    function automatic ghmt_pkg::result_t apply_event(
        input logic [ghmt_pkg::KIND_W-1:0] kind,
        input logic [ghmt_pkg::GOAL_W-1:0] goal,
        input logic [ghmt_pkg::GOAL_W-1:0] prev);
        ghmt_pkg::result_t r;
        ghmt_pkg::status_t st;
        st = ghmt_pkg::ST_OK;
        case (kind)
            ghmt_pkg::KIND_ADD:
                if (!goal_valid(goal))
                    st = ghmt_pkg::ST_INVALID;
                else if (goal_count[goal] == COUNT_FULL || file_count == COUNT_FULL)
                    st = ghmt_pkg::ST_OVERFLOW;
                else
                begin
                    goal_count[goal]++;
                    file_count++;
                end
            ghmt_pkg::KIND_REMOVE:
                if (!goal_valid(goal))
                    st = ghmt_pkg::ST_INVALID;
                else if (goal_count[goal] == '0)
                    st = ghmt_pkg::ST_ABSENT;
                else
                begin
                    goal_count[goal]--;
                    if (file_count != '0)
                        file_count--;
                end
            ghmt_pkg::KIND_CHANGE:
                if (!goal_valid(goal) || !goal_valid(prev))
                    st = ghmt_pkg::ST_INVALID;
                else if (goal_count[prev] == '0)
                    st = ghmt_pkg::ST_ABSENT;
                else
                begin
                    goal_count[prev]--;
                    goal_count[goal]++;
                end
            default:
                st = ghmt_pkg::ST_OK;
        endcase
        r.status         = st;
        r.effective_goal = top_goal();
        r.file_total     = ghmt_pkg::TOTAL_W'(file_count);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, field, got, want);
        mismatches++;
    endtask

    // result checker and receiver stall pattern
    initial
    begin
        ghmt_pkg::result_t want;
        int      hold_seen;
        int      hold_left;
        int      mode_left;
        bit      always_ready;
        logic [31:0] stall_bits;
        hold_seen    = 0;
        hold_left    = 0;
        mode_left    = 0;
        always_ready = 1'b1;
        stall_bits   = '1;
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_bus.valid && res_bus.ready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("transaction with none expected", res_bus.file_total,
                                    32'd0);
                else
                begin
                    want = results_due.pop_front();
                    if (res_bus.status !== want.status)
                        report_mismatch("status", 32'(res_bus.status), 32'(want.status));
                    if (res_bus.effective_goal !== want.effective_goal)
                        report_mismatch("effective_goal", 32'(res_bus.effective_goal),
                                        32'(want.effective_goal));
                    if (res_bus.file_total !== want.file_total)
                        report_mismatch("file_total", res_bus.file_total, want.file_total);
                end
            end
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = hold_len;
            end
            if (mode_left == 0)
            begin
                mode_left    = $urandom_range(32, 160);
                always_ready = ($urandom_range(0, 2) == 0);
                stall_bits   = $urandom;
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else if (always_ready)
                res_bus.ready <= 1'b1;
            else
                res_bus.ready <= stall_bits[cycle_count % 32];
        end
    end

    // called at a rising edge, returns at the edge where the transaction is accepted, or after a gap when gaps are on
    task automatic send_event(input logic [ghmt_pkg::KIND_W-1:0] kind,
                              input logic [ghmt_pkg::GOAL_W-1:0] goal,
                              input logic [ghmt_pkg::GOAL_W-1:0] prev);
        evt_bus.valid     <= 1'b1;
        evt_bus.kind      <= kind;
        evt_bus.goal      <= goal;
        evt_bus.prev_goal <= prev;
        @(posedge clk);
        while (!evt_bus.ready)
            @(posedge clk);
        results_due.push_back(apply_event(kind, goal, prev));
        if (gaps_on)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                evt_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    task automatic wait_drained();
        evt_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (results_due.size() != 0);
    endtask

    function automatic logic [ghmt_pkg::GOAL_W-1:0] any_valid_goal();
        return ghmt_pkg::GOAL_W'($urandom_range(ghmt_pkg::MIN_GOAL, MAX_GOAL));
    endfunction

    function automatic logic [ghmt_pkg::GOAL_W-1:0] bad_goal();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return ghmt_pkg::GOAL_W'($urandom_range(MAX_GOAL + 1, 255));
        endcase
    endfunction

    function automatic logic [ghmt_pkg::GOAL_W-1:0] present_goal();
        int start;
        int g;
        start = $urandom_range(ghmt_pkg::MIN_GOAL, MAX_GOAL);
        for (int i = 0; i < MAX_GOAL; i++)
        begin
            g = ghmt_pkg::MIN_GOAL + (start - ghmt_pkg::MIN_GOAL + i) % MAX_GOAL;
            if (goal_count[g] != '0)
                return ghmt_pkg::GOAL_W'(g);
        end
        return ghmt_pkg::GOAL_W'(start);
    endfunction

    task automatic send_random(input int add_pct, input int chg_pct);
        int r;
        int p;
        logic [ghmt_pkg::GOAL_W-1:0] g;
        logic [ghmt_pkg::GOAL_W-1:0] pg;
        r  = $urandom_range(0, 99);
        p  = $urandom_range(0, 9);
        pg = ghmt_pkg::GOAL_W'($urandom_range(0, 255));
        if (r < 2)
            send_event(KIND_UNUSED, ghmt_pkg::GOAL_W'($urandom_range(0, 255)), pg);
        else if (r < 2 + add_pct)
            send_event(ghmt_pkg::KIND_ADD, (p == 0) ? bad_goal() : any_valid_goal(), pg);
        else if (r < 2 + add_pct + chg_pct)
        begin
            pg = present_goal();
            g  = any_valid_goal();
            case (p)
                0: g  = bad_goal();
                1: pg = bad_goal();
                2: pg = any_valid_goal();
                3: g  = pg;
                default: ;
            endcase
            send_event(ghmt_pkg::KIND_CHANGE, g, pg);
        end
        else
        begin
            case (p)
                0: g = bad_goal();
                1: g = any_valid_goal();
                default: g = present_goal();
            endcase
            send_event(ghmt_pkg::KIND_REMOVE, g, pg);
        end
    endtask

    task automatic test_directed();
        send_event(ghmt_pkg::KIND_REMOVE, 8'd1, 8'd0);
        send_event(ghmt_pkg::KIND_CHANGE, 8'd1, 8'd2);
        send_event(ghmt_pkg::KIND_ADD, 8'd0, 8'd0);
        send_event(ghmt_pkg::KIND_ADD, 8'd21, 8'd0);
        send_event(ghmt_pkg::KIND_ADD, 8'd255, 8'd255);
        send_event(ghmt_pkg::KIND_REMOVE, 8'd0, 8'd0);
        send_event(ghmt_pkg::KIND_REMOVE, 8'd255, 8'd0);
        send_event(ghmt_pkg::KIND_ADD, 8'd1, 8'd255);
        send_event(ghmt_pkg::KIND_ADD, 8'd20, 8'd0);
        send_event(ghmt_pkg::KIND_ADD, 8'd20, 8'd170);
        send_event(ghmt_pkg::KIND_CHANGE, 8'd5, 8'd20);
        send_event(ghmt_pkg::KIND_CHANGE, 8'd21, 8'd1);
        send_event(ghmt_pkg::KIND_CHANGE, 8'd3, 8'd0);
        send_event(ghmt_pkg::KIND_CHANGE, 8'd255, 8'd255);
        send_event(ghmt_pkg::KIND_CHANGE, 8'd5, 8'd5);
        send_event(ghmt_pkg::KIND_CHANGE, 8'd6, 8'd7);
        send_event(KIND_UNUSED, 8'd255, 8'd255);
        send_event(ghmt_pkg::KIND_REMOVE, 8'd20, 8'd0);
        send_event(ghmt_pkg::KIND_REMOVE, 8'd20, 8'd0);
        send_event(ghmt_pkg::KIND_REMOVE, 8'd5, 8'd85);
        send_event(ghmt_pkg::KIND_REMOVE, 8'd1, 8'd0);
        send_event(KIND_UNUSED, 8'd0, 8'd0);
        wait_drained();
    endtask

    task automatic test_fill_drain();
        while (file_count != '0)
            send_event(ghmt_pkg::KIND_REMOVE, present_goal(), 8'd0);
        repeat (250)
            send_event(ghmt_pkg::KIND_ADD, 8'd7, ghmt_pkg::GOAL_W'($urandom_range(0, 255)));
        send_event(ghmt_pkg::KIND_ADD, 8'd7, 8'd0);
        send_event(ghmt_pkg::KIND_ADD, 8'd20, 8'd0);
        send_event(ghmt_pkg::KIND_ADD, 8'd0, 8'd0);
        send_event(ghmt_pkg::KIND_CHANGE, 8'd20, 8'd7);
        send_event(ghmt_pkg::KIND_ADD, 8'd7, 8'd0);
        send_event(ghmt_pkg::KIND_CHANGE, 8'd7, 8'd20);
        send_event(ghmt_pkg::KIND_REMOVE, 8'd7, 8'd0);
        send_event(ghmt_pkg::KIND_ADD, 8'd3, 8'd0);
        send_event(ghmt_pkg::KIND_ADD, 8'd3, 8'd0);
        send_event(KIND_UNUSED, 8'd3, 8'd0);
        while (file_count != '0)
            send_event(ghmt_pkg::KIND_REMOVE, present_goal(), 8'd0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_len = 80;
        hold_req++;
        gaps_on = 1'b0;
        repeat (40)
            send_random(60, 20);
        gaps_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_random();
        repeat (200)
            send_random(45, 25);
        repeat (250)
            send_random(85, 5);
        repeat (180)
            send_random(20, 55);
        repeat (220)
            send_random(10, 20);
        gaps_on = 1'b0;
        repeat (150)
            send_random(45, 25);
        gaps_on = 1'b1;
        wait_drained();
    endtask

    initial
    begin
        mismatches = 0;
        burst_left = 1;
        gaps_on    = 1'b1;
        hold_req   = 0;
        hold_len   = 0;
        file_count = '0;
        foreach (goal_count[g])
            goal_count[g] = '0;
        rst_n             <= 1'b0;
        evt_bus.valid     <= 1'b0;
        evt_bus.kind      <= '0;
        evt_bus.goal      <= '0;
        evt_bus.prev_goal <= '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_drain();
        test_backpressure();
        test_random();
        repeat (8)
            @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
